// ----- sv/isort_pkg.sv -----
package isort_pkg;

  localparam int MAX_ITEMS_DEF = 16;
  localparam int DATA_W        = 32;

  // register index of the order select
  localparam logic REG_DESC = 1'b0;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } out_item_t;

  typedef struct packed {
    logic walk_start;
    logic set_ovf;
    logic shift;
    logic place;
    logic emit;
    logic clr_run;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ahead;
    logic j_one;
    logic k_last;
  } dp_stat_t;

endpackage

// ----- sv/isort_ctrl.sv -----
module isort_ctrl import isort_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     last_in,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          last_nxt = last_in;
          if (stat.full) begin
            // store full: drop the item, still emit if the run ends here
            cmd.set_ovf = 1'b1;
            if (last_in) state_nxt = S_EMIT;
          end else begin
            cmd.walk_start = 1'b1;
            state_nxt = stat.empty ? S_PLACE : S_WALK;
          end
        end
      end
      S_WALK: begin
        if (stat.ahead) begin
          cmd.shift = 1'b1;
          state_nxt = stat.j_one ? S_PLACE : S_WALK;
        end else begin
          cmd.place = 1'b1;
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = last_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.k_last) begin
          cmd.clr_run = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- sv/isort_dp.sv -----
module isort_dp import isort_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     desc,
  output dp_stat_t                 stat,
  output out_item_t                out_item,
  output logic                     out_strobe
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic signed [DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [DATA_W-1:0] rd_data_r;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     wr_en;
  logic [AW-1:0]            j_r, j_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     strobe_r;
  logic                     olast_r, olast_nxt;
  logic                     oovf_r;

  assign stat.full   = (count_r == CW'(MAX_ITEMS));
  assign stat.empty  = (count_r == '0);
  assign stat.ahead  = desc ? (val_r > rd_data_r) : (val_r < rd_data_r);
  assign stat.j_one  = (j_r == AW'(1));
  assign stat.k_last = ((CW'(k_r) + CW'(1)) == count_r);

  always_comb begin
    rd_addr   = k_r;
    wr_en     = 1'b0;
    wr_addr   = j_r;
    wr_data   = val_r;
    val_nxt   = val_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    olast_nxt = olast_r;
    if (cmd.walk_start) begin
      val_nxt = in_value;
      j_nxt   = AW'(count_r);
      rd_addr = AW'(count_r - CW'(1));
    end
    if (cmd.set_ovf) ovf_nxt = 1'b1;
    if (cmd.shift) begin
      // move the stored entry up one slot and fetch the next lower one
      wr_en   = 1'b1;
      wr_data = rd_data_r;
      j_nxt   = j_r - AW'(1);
      rd_addr = j_r - AW'(2);
    end
    if (cmd.place) begin
      wr_en     = 1'b1;
      count_nxt = count_r + CW'(1);
    end
    if (cmd.emit) begin
      rd_addr   = k_r;
      k_nxt     = k_r + AW'(1);
      olast_nxt = stat.k_last;
    end
    if (cmd.clr_run) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      k_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r      <= '0;
      k_r      <= '0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      strobe_r <= cmd.emit;
    end
  end

  assign out_strobe            = strobe_r;
  assign out_item.sorted_value = rd_data_r;
  assign out_item.last_out     = olast_r;
  assign out_item.overflow     = oovf_r;

endmodule

// ----- sv/insertion_sort_with_order_core.sv -----
// channel  direction  handshake                       payload
// input    in         start & !busy                   in_item   (value, last_in)
// result   out        out_strobe, one per item        out_item  (sorted_value, last_out, overflow)
// config   in         psel & penable & pwrite         paddr, pwdata -> descending
//
// an item without last_in takes a start step, one shift step per entry that it passes in
// the insertion walk over the store's single read port, and a place step
// an item with last_in then adds emission of the whole store, one result per cycle
// a dropped item (store full) takes only the start step, plus emission if it ends the run
// rst_n is synchronous, active low; the store holds no reset and needs no clearing
// results cannot be stalled; busy falls in the cycle the last result is on the ports
module insertion_sort_with_order_core import isort_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     desc_r, desc_nxt;
  logic     ctrl_start;

  assign pready = 1'b1;

  always_comb begin
    desc_nxt = desc_r;
    if (psel && penable && pwrite && (paddr[2] == REG_DESC)) desc_nxt = pwdata[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) desc_r <= 1'b0;
    else        desc_r <= desc_nxt;
  end

  assign prdata = (paddr[2] == REG_DESC) ? {31'b0, desc_r} : 32'b0;

  assign ctrl_start = start && !busy;

  isort_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ctrl_start),
    .last_in (in_item.last_in),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  isort_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value   (in_item.value),
    .desc       (desc_r),
    .stat       (stat),
    .out_item   (out_item),
    .out_strobe (out_strobe)
  );

`ifndef SYNTHESIS
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result issued without a run in progress");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.last_in) |=> busy)
    else $error("run end item did not start emission");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last_out) |=> !out_strobe)
    else $error("result after final item of run");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && stat.k_last) |=> (stat.empty && !busy))
    else $error("run state not cleared after emission");
`endif

endmodule

// ----- sim/insertion_sort_with_order_core_tb.sv -----
`timescale 1ns / 1ps

module insertion_sort_with_order_core_tb;
  import isort_pkg::*;

  localparam int RUN_CAP = MAX_ITEMS_DEF;
  localparam logic [2:0] DESC_ADDR = 3'(4 * int'(REG_DESC));
  localparam int SETTLE_CYCLES = RUN_CAP + 6;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 225;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_strobe;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pending_t  pending_items[$];
  out_item_t expected_sorted[$];

  // predictor state
  logic signed [DATA_W-1:0] run_store [RUN_CAP];
  int                       run_len = 0;
  logic                     run_dropped = 1'b0;
  logic                     order_desc = 1'b0;

  int errors = 0;
  int idle_cnt = 0;
  int stall_cycles = 0;
  int random_pushed = 0;

  insertion_sort_with_order_core uut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit precedes(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
    return order_desc ? (a > b) : (a < b);
  endfunction

  // stable insertion; a run closed by last_in yields the whole sorted store
  function automatic void insert_and_emit(in_item_t it);
    logic signed [DATA_W-1:0] v;
    int                       j;
    out_item_t                r;
    v = it.value;
    if (run_len >= RUN_CAP) begin
      run_dropped = 1'b1;
    end else begin
      j = run_len;
      while (j > 0 && precedes(v, run_store[j-1])) begin
        run_store[j] = run_store[j-1];
        j--;
      end
      run_store[j] = v;
      run_len++;
    end
    if (it.last_in) begin
      for (int k = 0; k < run_len; k++) begin
        r.sorted_value = run_store[k];
        r.last_out     = (k == run_len - 1);
        r.overflow     = run_dropped;
        expected_sorted.push_back(r);
      end
      run_len = 0;
      run_dropped = 1'b0;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_cnt <= 0;
    end else if (start) begin
      if (!busy) begin
        if (pending_items.size() != 0 && pending_items[0].gap == 0) begin
          in_item <= pending_items[0].item;
          pending_items.delete(0);
        end else begin
          start <= 1'b0;
        end
      end
    end else if (pending_items.size() != 0) begin
      if (idle_cnt >= pending_items[0].gap) begin
        in_item <= pending_items[0].item;
        pending_items.delete(0);
        start <= 1'b1;
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  // monitor: check results first, the final result may share an edge with the next item
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_sorted.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d last=%b ovf=%b",
                   $time, out_item.sorted_value, out_item.last_out, out_item.overflow);
          errors++;
        end else begin
          if (out_item.sorted_value !== expected_sorted[0].sorted_value) begin
            $display("%0t: sorted_value expected %0d got %0d", $time,
                     expected_sorted[0].sorted_value, out_item.sorted_value);
            errors++;
          end
          if (out_item.last_out !== expected_sorted[0].last_out) begin
            $display("%0t: last_out expected %b got %b", $time,
                     expected_sorted[0].last_out, out_item.last_out);
            errors++;
          end
          if (out_item.overflow !== expected_sorted[0].overflow) begin
            $display("%0t: overflow expected %b got %b", $time,
                     expected_sorted[0].overflow, out_item.overflow);
            errors++;
          end
          expected_sorted.delete(0);
        end
      end
      if (start && !busy) insert_and_emit(in_item);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe || (psel && penable)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_item(logic signed [DATA_W-1:0] v, logic last, int unsigned gap);
    pending_t p;
    p.item.value = v;
    p.item.last_in = last;
    p.gap = gap;
    pending_items.push_back(p);
  endtask

  task automatic set_order(logic desc);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DESC_ADDR;
    pwdata <= {31'($urandom()), desc};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    order_desc = desc;
    @(negedge clk);
  endtask

  // block stays busy on items without results, so let it settle after the last result
  task automatic wait_idle();
    while (pending_items.size() != 0 || start || expected_sorted.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(bit dup_heavy);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh7FFF_FFFF;
    if (r == 1) return 32'sh8000_0000;
    if (dup_heavy || r < 4) return $signed($urandom_range(0, 7)) - 4;
    return $signed($urandom());
  endfunction

  task automatic push_run(int len, bit close_run);
    bit dup_heavy;
    bit no_gaps;
    dup_heavy = ($urandom_range(0, 2) == 0);
    no_gaps = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < len; i++) begin
      push_item(pick_value(dup_heavy), close_run && (i == len - 1),
                no_gaps ? 0 : $urandom_range(0, 18));
      random_pushed++;
    end
  endtask

  initial begin
    int nruns;
    int len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset order is ascending: single item run at the negative extreme
    push_item(32'sh8000_0000, 1'b1, 0);
    wait_idle();

    set_order(1'b0);
    push_item(32'sh7FFF_FFFF, 1'b0, 0);
    push_item(32'sh8000_0000, 1'b0, 3);
    push_item(32'sh0000_0000, 1'b0, 0);
    push_item(-32'sd1, 1'b0, 18);
    push_item(32'sh7FFF_FFFF, 1'b0, 0);
    push_item(32'sh0000_0000, 1'b1, 1);
    wait_idle();

    // store full: one dropped item, then a dropped item that closes the run
    set_order(1'b1);
    for (int i = 0; i < RUN_CAP; i++)
      push_item((i % 3 == 0) ? -$signed(i * 1000) : $signed(i * 77), 1'b0, i % 2);
    push_item(32'sh7FFF_FFFF, 1'b0, 0);
    push_item(32'sh8000_0000, 1'b1, 0);
    wait_idle();

    // order flipped in the middle of a run
    push_item(32'sd5, 1'b0, 0);
    push_item(-32'sd5, 1'b0, 2);
    wait_idle();
    set_order(1'b0);
    push_item(32'sd0, 1'b1, 0);
    wait_idle();

    while (random_pushed < RANDOM_ITEMS) begin
      set_order(1'($urandom_range(0, 1)));
      nruns = $urandom_range(1, 4);
      for (int r = 0; r < nruns; r++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(RUN_CAP + 1, RUN_CAP + 4)
                                          : $urandom_range(1, 8);
        if ($urandom_range(0, 5) == 0) len = RUN_CAP;
        push_run(len, 1'b1);
      end
      // leave a run open so the next order setting lands mid-run
      if ($urandom_range(0, 3) == 0) push_run($urandom_range(1, 5), 1'b0);
      wait_idle();
    end
    push_run(1, 1'b1);
    wait_idle();

    if (errors == 0 && expected_sorted.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/isort_pkg.sv
sv/isort_ctrl.sv
sv/isort_dp.sv
sv/insertion_sort_with_order_core.sv
sim/insertion_sort_with_order_core_tb.sv
